[rtl/core/ptgl_pkg.sv]
package ptgl_pkg;

    localparam int LINE_STEP       = 16;
    localparam int MAX_GLYPH_WIDTH = 16;

    localparam int COORD_W = 16;
    localparam int CODE_W  = 8;
    localparam int WIDTH_W = 5;
    localparam int TABLE_DEPTH = 256;

    localparam logic [CODE_W-1:0] CODE_END        = 8'hff;
    localparam logic [CODE_W-1:0] CODE_NEWLINE    = 8'hfe;
    localparam logic [CODE_W-1:0] CODE_CTRL_FIRST = 8'hf7;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_RESUME = 2'd1,
        MODE_WIDTH  = 2'd2,
        MODE_START  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_RUNNING = 3'd0,
        ST_DONE    = 3'd1,
        ST_WAIT    = 3'd2,
        ST_ERROR   = 3'd3,
        ST_TRUNC   = 3'd4
    } status_t;

    typedef enum logic {
        REG_ORIGIN_X = 1'b0,
        REG_ORIGIN_Y = 1'b1
    } reg_index_t;

endpackage

[rtl/core/proportional_text_glyph_layout.sv]
// Proportional text glyph layout. Each input transfer carries one command
// (text byte, resume, width table write or dialogue start) and produces exactly
// one result transfer holding the status after that command and, for a printable
// byte, the glyph's position and width. The block takes one item per clock
// cycle while the result channel is not stalled; each item passes through the
// stage 1 register and then the result register. The input transfer edge itself
// performs the registered read of the 256 x 8 width memory (read and written at
// input transfer time, so a width write is seen by the very next byte), and the
// layout decision is loaded into the result register and the pen updated as the
// item leaves stage 1. A stalled result register is backed by the one stage in
// front of it, so input keeps flowing until both are full. The width memory is
// not cleared by reset: every glyph index used must have its width written first.
// origin_x and origin_y are written through the configuration port; the user
// must write them only while the block is idle, which the block does not enforce.
module proportional_text_glyph_layout (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [ptgl_pkg::COORD_W-1:0]          cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            mode,
    input  logic [ptgl_pkg::CODE_W-1:0]           code,
    input  logic [7:0]                            width_value,
    input  logic                                  last_byte,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [2:0]                            status,
    output logic                                  glyph_valid,
    output logic [ptgl_pkg::CODE_W-1:0]           glyph_code,
    output logic signed [ptgl_pkg::COORD_W-1:0]   glyph_x,
    output logic signed [ptgl_pkg::COORD_W-1:0]   glyph_y,
    output logic [ptgl_pkg::WIDTH_W-1:0]          glyph_width,
    output logic [ptgl_pkg::CODE_W-1:0]           control_code
);

    localparam int CW = ptgl_pkg::COORD_W;

    // configuration registers
    logic signed [CW-1:0] origin_x_reg;
    logic signed [CW-1:0] origin_y_reg;

    // layout state
    ptgl_pkg::status_t    run_status_reg, run_status_next;
    logic signed [CW-1:0] pen_x_reg, pen_x_next;
    logic signed [CW-1:0] pen_y_reg, pen_y_next;
    logic [7:0]           held_control_reg, held_control_next;
    logic                 end_after_resume_reg, end_after_resume_next;

    // stage 1: captured item and width memory read
    logic                 s1_valid_reg;
    ptgl_pkg::mode_t      s1_mode_reg;
    logic [7:0]           s1_code_reg;
    logic                 s1_last_reg;
    logic [7:0]           s1_width_reg;

    logic [7:0] width_mem [ptgl_pkg::TABLE_DEPTH];

    // result register
    logic                 out_valid_reg;
    ptgl_pkg::status_t    status_reg, status_next;
    logic                 glyph_valid_reg, glyph_valid_next;
    logic [7:0]           glyph_code_reg, glyph_code_next;
    logic signed [CW-1:0] glyph_x_reg, glyph_x_next;
    logic signed [CW-1:0] glyph_y_reg, glyph_y_next;
    logic [4:0]           glyph_width_reg, glyph_width_next;
    logic [7:0]           control_code_reg, control_code_next;

    logic in_fire;
    logic s1_move;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (ptgl_pkg::reg_index_t'(cfg_index))
                ptgl_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                ptgl_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // width memory: write and registered read at input transfer
    always_ff @(posedge clk)
    begin
        if (in_fire && (ptgl_pkg::mode_t'(mode) == ptgl_pkg::MODE_WIDTH))
        begin
            width_mem[code] <= width_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_width_reg <= width_mem[code];
            s1_mode_reg  <= ptgl_pkg::mode_t'(mode);
            s1_code_reg  <= code;
            s1_last_reg  <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 2: layout decision
    logic signed [CW:0] x_sum;
    logic signed [CW:0] y_sum;
    logic               x_over;
    logic               y_over;
    logic               width_bad;

    // widened sums: overflow when the 17-bit signed result exceeds the signed 16-bit maximum
    assign x_sum  = {pen_x_reg[CW-1], pen_x_reg} + (CW+1)'({1'b0, s1_width_reg});
    assign y_sum  = {pen_y_reg[CW-1], pen_y_reg} + (CW+1)'(ptgl_pkg::LINE_STEP);
    assign x_over = !x_sum[CW] && x_sum[CW-1];
    assign y_over = !y_sum[CW] && y_sum[CW-1];
    assign width_bad = (s1_width_reg == 8'd0)
                    || (s1_width_reg > 8'(ptgl_pkg::MAX_GLYPH_WIDTH));

    always_comb
    begin
        run_status_next       = run_status_reg;
        pen_x_next            = pen_x_reg;
        pen_y_next            = pen_y_reg;
        held_control_next     = held_control_reg;
        end_after_resume_next = end_after_resume_reg;
        glyph_valid_next      = 1'b0;
        glyph_code_next       = '0;
        glyph_x_next          = '0;
        glyph_y_next          = '0;
        glyph_width_next      = '0;

        unique case (s1_mode_reg)
            ptgl_pkg::MODE_START:
            begin
                pen_x_next            = origin_x_reg;
                pen_y_next            = origin_y_reg;
                held_control_next     = '0;
                end_after_resume_next = 1'b0;
                run_status_next       = ptgl_pkg::ST_RUNNING;
            end
            ptgl_pkg::MODE_WIDTH: ;
            ptgl_pkg::MODE_RESUME:
            begin
                if (run_status_reg == ptgl_pkg::ST_WAIT)
                begin
                    held_control_next     = '0;
                    end_after_resume_next = 1'b0;
                    run_status_next       = end_after_resume_reg ? ptgl_pkg::ST_TRUNC
                                                                 : ptgl_pkg::ST_RUNNING;
                end
            end
            ptgl_pkg::MODE_TEXT:
            begin
                if (run_status_reg == ptgl_pkg::ST_RUNNING)
                begin
                    if (s1_code_reg == ptgl_pkg::CODE_END)
                    begin
                        run_status_next = ptgl_pkg::ST_DONE;
                    end
                    else if (s1_code_reg == ptgl_pkg::CODE_NEWLINE)
                    begin
                        if (y_over)
                        begin
                            run_status_next = ptgl_pkg::ST_ERROR;
                        end
                        else
                        begin
                            pen_y_next = y_sum[CW-1:0];
                            pen_x_next = origin_x_reg;
                            if (s1_last_reg)
                            begin
                                run_status_next = ptgl_pkg::ST_TRUNC;
                            end
                        end
                    end
                    else if (s1_code_reg >= ptgl_pkg::CODE_CTRL_FIRST)
                    begin
                        held_control_next     = s1_code_reg;
                        end_after_resume_next = s1_last_reg;
                        run_status_next       = ptgl_pkg::ST_WAIT;
                    end
                    else if (width_bad || x_over)
                    begin
                        run_status_next = ptgl_pkg::ST_ERROR;
                    end
                    else
                    begin
                        glyph_valid_next = 1'b1;
                        glyph_code_next  = s1_code_reg;
                        glyph_x_next     = pen_x_reg;
                        glyph_y_next     = pen_y_reg;
                        glyph_width_next = s1_width_reg[4:0];
                        pen_x_next       = x_sum[CW-1:0];
                        if (s1_last_reg)
                        begin
                            run_status_next = ptgl_pkg::ST_TRUNC;
                        end
                    end
                end
            end
            default: ;
        endcase

        status_next       = run_status_next;
        control_code_next = (run_status_next == ptgl_pkg::ST_WAIT) ? held_control_next
                                                                    : 8'd0;
    end

    // advance state as the item leaves stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_status_reg       <= ptgl_pkg::ST_RUNNING;
            pen_x_reg            <= '0;
            pen_y_reg            <= '0;
            held_control_reg     <= '0;
            end_after_resume_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            run_status_reg       <= run_status_next;
            pen_x_reg            <= pen_x_next;
            pen_y_reg            <= pen_y_next;
            held_control_reg     <= held_control_next;
            end_after_resume_reg <= end_after_resume_next;
        end
    end

    // result register: load on advance, hold while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            status_reg       <= status_next;
            glyph_valid_reg  <= glyph_valid_next;
            glyph_code_reg   <= glyph_code_next;
            glyph_x_reg      <= glyph_x_next;
            glyph_y_reg      <= glyph_y_next;
            glyph_width_reg  <= glyph_width_next;
            control_code_reg <= control_code_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign glyph_valid  = glyph_valid_reg;
    assign glyph_code   = glyph_code_reg;
    assign glyph_x      = glyph_x_reg;
    assign glyph_y      = glyph_y_reg;
    assign glyph_width  = glyph_width_reg;
    assign control_code = control_code_reg;

endmodule

[rtl/core/ptgl_checker.sv]
module ptgl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        glyph_valid,
    input logic [4:0]  glyph_width,
    input logic [7:0]  control_code
);

    // a placed glyph only comes with a running or truncated status
    a_glyph_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && glyph_valid) |->
            (status == ptgl_pkg::ST_RUNNING || status == ptgl_pkg::ST_TRUNC))
        else $error("glyph placed with status %0d", status);

    // a placed glyph has a legal width
    a_glyph_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && glyph_valid) |->
            (glyph_width != 5'd0
             && glyph_width <= 5'(ptgl_pkg::MAX_GLYPH_WIDTH)))
        else $error("glyph width %0d out of range", glyph_width);

    // control code shown only while waiting, and then it is a control byte
    a_ctrl_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((status == ptgl_pkg::ST_WAIT) ? (control_code >= ptgl_pkg::CODE_CTRL_FIRST)
                                            : (control_code == 8'd0)))
        else $error("control code %0d with status %0d", control_code, status);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("stalled result changed");

endmodule

bind proportional_text_glyph_layout ptgl_checker u_ptgl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .glyph_valid  (glyph_valid),
    .glyph_width  (glyph_width),
    .control_code (control_code)
);
